// File: rtl/rfrl_pkg.sv
`default_nettype none
package rfrl_pkg;

    localparam int unsigned MAX_RECORDS_DEF = 32;

    localparam logic [7:0] START_BYTE = 8'h7E;
    localparam logic [7:0] CHECK_BASE = 8'hFF;

    // records completed in a frame: at most 255 / 3
    localparam int unsigned REC_W = 7;

    localparam logic KIND_LINK   = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_GOOD      = 2'd0,
        ST_CSUM_BAD  = 2'd1,
        ST_TOO_LONG  = 2'd2,
        ST_LOOKUP    = 2'd3
    } status_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] link_byte;
        logic [7:0] lookup_key;
    } req_item_t;

    typedef struct packed {
        status_t     status;
        logic [5:0]  record_count;
        logic        found;
        logic [15:0] value;
    } rsp_item_t;

endpackage
`default_nettype wire

// File: rtl/rfrl_stream_if.sv
`default_nettype none
interface rfrl_stream_if
    import rfrl_pkg::*;
#(
    parameter type T = req_item_t
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/record_frame_receiver_lookup.sv
`default_nettype none
// channel | dir | item
// --------+-----+-----------------------------------------------
// req     | in  | kind, link_byte, lookup_key
// rsp     | out | status, record_count, found, value
//
// a link byte is taken while idle; on the checksum byte the frame result is
// registered, then moves into the output register once rsp is free
// a lookup reads the record store through its single read port, scanned one
// entry per cycle up to record_count, and ends at the first matching key
// reset clears the framer and control; the record store is not cleared
// req stalls while a lookup scans or a result waits to enter rsp
module record_frame_receiver_lookup
    import rfrl_pkg::*;
#(
    parameter int unsigned MAX_RECORDS = MAX_RECORDS_DEF
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    rfrl_stream_if.sink   req,
    rfrl_stream_if.source rsp
);

    localparam int unsigned IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_RECORDS + 1);
    localparam logic [8:0]  LONG_LIMIT = 9'(3 * MAX_RECORDS);
    localparam logic [REC_W-1:0] REC_MAX = REC_W'(MAX_RECORDS);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT} ctl_state_t;
    typedef enum logic [1:0] {PH_HUNT, PH_LENGTH, PH_PAYLOAD, PH_CHECK} phase_t;

    // record store: key in [23:16], value in [15:0]
    logic [23:0] store_mem [MAX_RECORDS];
    logic [23:0] rd_reg;

    ctl_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] seen_reg, seen_next;
    logic [7:0] sum_reg, sum_next;
    logic [1:0] pos_reg, pos_next;            // byte place within a record
    logic [15:0] partial_reg, partial_next;
    logic [REC_W-1:0] rec_reg, rec_next;      // records completed this frame
    logic [REC_W-1:0] valid_reg, valid_next;  // records held from good frame
    logic [7:0] key_reg, key_next;
    logic [CNT_W-1:0] iss_reg, iss_next;      // next store entry to read
    logic       pend_reg, pend_next;          // rd_reg holds an entry to check
    rsp_item_t  res_reg, res_next;
    logic       rsp_valid_reg, rsp_valid_next;
    rsp_item_t  rsp_data_reg, rsp_data_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [23:0]       mem_wdata;
    logic              mem_re;
    logic [7:0]        csum_want;
    logic [7:0]        seen_inc;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    assign csum_want = CHECK_BASE - sum_reg;
    assign seen_inc  = seen_reg + 8'd1;
    assign mem_waddr = rec_reg[IDX_W-1:0];
    assign mem_wdata = {partial_reg, req.data.link_byte};

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        len_next       = len_reg;
        seen_next      = seen_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        partial_next   = partial_reg;
        rec_next       = rec_reg;
        valid_next     = valid_reg;
        key_next       = key_reg;
        iss_next       = iss_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.data.kind == KIND_LOOKUP)
                    begin
                        key_next   = req.data.lookup_key;
                        iss_next   = '0;
                        pend_next  = 1'b0;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_HUNT:
                            begin
                                if (req.data.link_byte == START_BYTE)
                                begin
                                    phase_next = PH_LENGTH;
                                    valid_next = '0;
                                end
                            end
                            PH_LENGTH:
                            begin
                                len_next     = req.data.link_byte;
                                seen_next    = '0;
                                sum_next     = '0;
                                pos_next     = '0;
                                partial_next = '0;
                                rec_next     = '0;
                                phase_next   = (req.data.link_byte == 8'd0) ?
                                               PH_CHECK : PH_PAYLOAD;
                            end
                            PH_PAYLOAD:
                            begin
                                sum_next  = sum_reg + req.data.link_byte;
                                seen_next = seen_inc;
                                case (pos_reg)
                                    2'd0:
                                    begin
                                        partial_next = {req.data.link_byte, 8'd0};
                                        pos_next     = 2'd1;
                                    end
                                    2'd1:
                                    begin
                                        partial_next = {partial_reg[15:8],
                                                        req.data.link_byte};
                                        pos_next     = 2'd2;
                                    end
                                    default:
                                    begin
                                        mem_we   = (rec_reg < REC_MAX);
                                        rec_next = rec_reg + 1'b1;
                                        pos_next = 2'd0;
                                    end
                                endcase
                                if (seen_inc == len_reg)
                                begin
                                    phase_next = PH_CHECK;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_HUNT;
                                if ({1'b0, len_reg} > LONG_LIMIT)
                                begin
                                    valid_next     = '0;
                                    res_next.status = ST_TOO_LONG;
                                end
                                else if (req.data.link_byte != csum_want)
                                begin
                                    valid_next     = '0;
                                    res_next.status = ST_CSUM_BAD;
                                end
                                else
                                begin
                                    valid_next     = rec_reg;
                                    res_next.status = ST_GOOD;
                                end
                                res_next.record_count = valid_next[5:0];
                                res_next.found        = 1'b0;
                                res_next.value        = '0;
                                state_next            = S_EMIT;
                            end
                        endcase
                    end
                end
            end
            S_SCAN:
            begin
                if (pend_reg && (rd_reg[23:16] == key_reg))
                begin
                    res_next.status       = ST_LOOKUP;
                    res_next.record_count = valid_reg[5:0];
                    res_next.found        = 1'b1;
                    res_next.value        = rd_reg[15:0];
                    state_next            = S_EMIT;
                end
                else if (REC_W'(iss_reg) < valid_reg)
                begin
                    mem_re    = 1'b1;
                    iss_next  = iss_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else if (!pend_reg)
                begin
                    res_next.status       = ST_LOOKUP;
                    res_next.record_count = valid_reg[5:0];
                    res_next.found        = 1'b0;
                    res_next.value        = '0;
                    state_next            = S_EMIT;
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end
            S_EMIT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_HUNT;
            len_reg       <= '0;
            seen_reg      <= '0;
            sum_reg       <= '0;
            pos_reg       <= '0;
            partial_reg   <= '0;
            rec_reg       <= '0;
            valid_reg     <= '0;
            key_reg       <= '0;
            iss_reg       <= '0;
            pend_reg      <= 1'b0;
            res_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            seen_reg      <= seen_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            partial_reg   <= partial_next;
            rec_reg       <= rec_next;
            valid_reg     <= valid_next;
            key_reg       <= key_next;
            iss_reg       <= iss_next;
            pend_reg      <= pend_next;
            res_reg       <= res_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

    // one write port for the framer, one registered read port for the scan
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= store_mem[iss_reg[IDX_W-1:0]];
        end
    end

endmodule
`default_nettype wire
